### sv/acpu_pkg.sv
// Package for the accumulator CPU execute unit.
// Holds widths, command codes and the controller/datapath command bundle; no dependencies.
package acpu_pkg;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 10;
  localparam int MEM_DEPTH = 1024;
  localparam int CMD_W   = 5;
  localparam int CNT_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOP     = 5'd0,
    CMD_AC_MQ   = 5'd1,
    CMD_MQ_M    = 5'd2,
    CMD_M_AC    = 5'd3,
    CMD_AC_M    = 5'd4,
    CMD_NEG     = 5'd5,
    CMD_ABS     = 5'd6,
    CMD_NABS    = 5'd7,
    CMD_JUMP    = 5'd8,
    CMD_JUMPP   = 5'd9,
    CMD_ADD     = 5'd10,
    CMD_ADDA    = 5'd11,
    CMD_SUB     = 5'd12,
    CMD_SUBA    = 5'd13,
    CMD_MUL     = 5'd14,
    CMD_DIV     = 5'd15,
    CMD_PRELOAD = 5'd16,
    CMD_SETPC   = 5'd17
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture request, start memory read
    logic clr_mem;   // write zero at clear address
    logic exec;      // execute simple command / start iterate
    logic step;      // one mul/div iteration
    logic finish;    // commit mul/div
  } dp_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic iter_cmd;  // mul or div with nonzero divisor
    logic iter_last; // final iteration
    logic clr_last;  // last clear address
  } dp_stat_t;

endpackage

### sv/acpu_datapath.sv
// Datapath: AC, MQ, PC, data memory and a shared shift-add / restoring-divide unit.
// Depends on acpu_pkg.
module acpu_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  acpu_pkg::dp_ctrl_t             ctrl,
  output acpu_pkg::dp_stat_t             stat,
  input  logic [acpu_pkg::CMD_W-1:0]     in_command,
  input  logic [acpu_pkg::ADDR_W-1:0]    in_address,
  input  logic signed [acpu_pkg::WORD_W-1:0] in_word_data,
  output logic signed [acpu_pkg::WORD_W-1:0] acc_o,
  output logic signed [acpu_pkg::WORD_W-1:0] mq_o,
  output logic [acpu_pkg::ADDR_W-1:0]    pc_o,
  output logic                           dz_o
);
  import acpu_pkg::*;

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] m_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [WORD_W-1:0] wd_r;
  logic [WORD_W-1:0] ac_r, mq_r;
  logic [ADDR_W-1:0] pc_r, clr_r;
  logic              dz_r;
  logic [WORD_W-1:0] a_r, b_r, p_r, rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              qneg_r, rneg_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [WORD_W-1:0] mem_wd, abs_m, res;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_sh;

  assign abs_m = m_r[WORD_W-1] ? (~m_r + 1'b1) : m_r;
  assign rem_sh = {rem_r[WORD_W-2:0], a_r[WORD_W-1]};
  assign trial = {1'b0, rem_sh} - {1'b0, b_r};

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = ac_r;
    if (ctrl.clr_mem) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else if (ctrl.exec && cmd_r == CMD_M_AC) begin
      mem_we = 1'b1;
    end else if (ctrl.exec && cmd_r == CMD_PRELOAD) begin
      mem_we = 1'b1;
      mem_wd = wd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (ctrl.latch) m_r <= mem[in_address];
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
      wd_r   <= in_word_data;
    end
  end

  assign stat.iter_cmd  = (cmd_r == CMD_MUL) || (cmd_r == CMD_DIV && m_r != '0);
  assign stat.iter_last = (cnt_r == CNT_W'(WORD_W - 1));
  assign stat.clr_last  = (clr_r == ADDR_W'(MEM_DEPTH - 1));

  always_comb begin
    res = p_r;
    if (cmd_r == CMD_DIV) res = qneg_r ? (~a_r + 1'b1) : a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_r <= '0; mq_r <= '0; pc_r <= '0; dz_r <= 1'b0; clr_r <= '0; cnt_r <= '0;
    end else begin
      if (ctrl.clr_mem) clr_r <= clr_r + 1'b1;
      if (ctrl.exec) begin
        dz_r  <= 1'b0;
        cnt_r <= '0;
        pc_r  <= pc_r + 1'b1;
        unique case (cmd_r)
          CMD_AC_MQ: ac_r <= mq_r;
          CMD_MQ_M:  mq_r <= m_r;
          CMD_AC_M:  ac_r <= m_r;
          CMD_NEG:   ac_r <= ~m_r + 1'b1;
          CMD_ABS:   ac_r <= abs_m;
          CMD_NABS:  ac_r <= ~abs_m + 1'b1;
          CMD_JUMP:  pc_r <= addr_r;
          CMD_JUMPP: if (!ac_r[WORD_W-1]) pc_r <= addr_r;
          CMD_ADD:   ac_r <= ac_r + m_r;
          CMD_ADDA:  ac_r <= ac_r + abs_m;
          CMD_SUB:   ac_r <= ac_r - m_r;
          CMD_SUBA:  ac_r <= ac_r - abs_m;
          CMD_MUL: begin
            a_r <= mq_r; b_r <= m_r; p_r <= '0;
          end
          CMD_DIV: begin
            if (m_r == '0) dz_r <= 1'b1;
            a_r    <= ac_r[WORD_W-1] ? (~ac_r + 1'b1) : ac_r;
            b_r    <= abs_m;
            rem_r  <= '0;
            qneg_r <= ac_r[WORD_W-1] ^ m_r[WORD_W-1];
            rneg_r <= ac_r[WORD_W-1];
          end
          CMD_PRELOAD: pc_r <= pc_r;
          CMD_SETPC:   pc_r <= addr_r;
          CMD_NOP, CMD_M_AC: ;
          default: pc_r <= pc_r;
        endcase
      end
      if (ctrl.step) begin
        cnt_r <= cnt_r + 1'b1;
        if (cmd_r == CMD_MUL) begin
          if (a_r[0]) p_r <= p_r + b_r;
          a_r <= a_r >> 1;
          b_r <= b_r << 1;
        end else begin
          if (!trial[WORD_W]) begin
            rem_r <= trial[WORD_W-1:0];
            a_r   <= {a_r[WORD_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            a_r   <= {a_r[WORD_W-2:0], 1'b0};
          end
        end
      end
      if (ctrl.finish) begin
        if (cmd_r == CMD_DIV) begin
          mq_r <= res;
          ac_r <= rneg_r ? (~rem_r + 1'b1) : rem_r;
        end else begin
          ac_r <= res;
        end
      end
    end
  end

  assign acc_o = ac_r;
  assign mq_o  = mq_r;
  assign pc_o  = pc_r;
  assign dz_o  = dz_r;

endmodule

### sv/acpu_ctrl.sv
// Controller FSM: memory clear after reset, request sequencing, output handshake.
// Depends on acpu_pkg.
module acpu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output acpu_pkg::dp_ctrl_t ctrl,
  input  acpu_pkg::dp_stat_t stat
);
  import acpu_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_ITER, S_FIN, S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    ctrl = '0;
    ctrl.clr_mem = (state_r == S_CLEAR);
    ctrl.latch   = in_valid && in_ready;
    ctrl.exec    = (state_r == S_READ);
    ctrl.step    = (state_r == S_ITER);
    ctrl.finish  = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: if (stat.clr_last) state_r <= S_IDLE;
        S_IDLE:  if (in_valid) state_r <= S_READ;
        S_READ: begin
          if (stat.iter_cmd) state_r <= S_ITER;
          else begin
            state_r     <= S_OUT;
            out_valid_r <= 1'b1;
          end
        end
        S_ITER:  if (stat.iter_last) state_r <= S_FIN;
        S_FIN: begin
          state_r     <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/accumulator_cpu_execute_unit.sv
// Top level of the accumulator CPU execute unit: controller plus datapath.
// Depends on acpu_pkg, acpu_ctrl, acpu_datapath.
// One request at a time. Simple commands, and a divide with a zero divisor, go from
// accept through the execute state to the result; multiply and divide run a 32-step
// shift-add / restoring-divide unit and then a finish state. in_ready rises again the
// cycle after the result is taken. After reset the 1024-word memory is cleared,
// one word a cycle, before in_ready rises. Divide by zero keeps AC and MQ and sets
// divide_by_zero.
module accumulator_cpu_execute_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [acpu_pkg::CMD_W-1:0]         in_command,
  input  logic [acpu_pkg::ADDR_W-1:0]        in_address,
  input  logic signed [acpu_pkg::WORD_W-1:0] in_word_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [acpu_pkg::WORD_W-1:0] out_acc_value,
  output logic signed [acpu_pkg::WORD_W-1:0] out_mq_value,
  output logic [acpu_pkg::ADDR_W-1:0]        out_pc_value,
  output logic                               out_divide_by_zero
);
  import acpu_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  acpu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .ctrl, .stat
  );

  acpu_datapath u_dp (
    .clk, .rst_n, .ctrl, .stat, .in_command, .in_address, .in_word_data,
    .acc_o(out_acc_value), .mq_o(out_mq_value), .pc_o(out_pc_value),
    .dz_o(out_divide_by_zero)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.clr_mem, ctrl.exec, ctrl.step, ctrl.finish}))
    else $error("overlapping datapath commands");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_acc_value) && $stable(out_pc_value))
    else $error("result changed while stalled");

endmodule

### sim/acpu_checker.sv
// Checker for the accumulator CPU execute unit: watches both channels,
// predicts each result from its own model of AC, MQ, PC and memory, compares.
// Depends on acpu_pkg.
module acpu_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [acpu_pkg::CMD_W-1:0]         in_command,
  input  logic [acpu_pkg::ADDR_W-1:0]        in_address,
  input  logic signed [acpu_pkg::WORD_W-1:0] in_word_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [acpu_pkg::WORD_W-1:0] out_acc_value,
  input  logic signed [acpu_pkg::WORD_W-1:0] out_mq_value,
  input  logic [acpu_pkg::ADDR_W-1:0]        out_pc_value,
  input  logic                               out_divide_by_zero,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen
);
  import acpu_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] mq;
    logic [ADDR_W-1:0] pc;
    logic              dz;
  } cpu_state_t;

  logic [WORD_W-1:0] acc_r, mq_r;
  logic [ADDR_W-1:0] pc_r;
  logic [WORD_W-1:0] mem_r [MEM_DEPTH];
  cpu_state_t        expected_q[$];

  function automatic logic [WORD_W-1:0] abs_word(logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? -v : v;
  endfunction

  task automatic execute(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                         input logic [WORD_W-1:0] wd);
    logic [WORD_W-1:0] m, ma, mb, q, r;
    logic [ADDR_W-1:0] npc;
    logic dz;
    m   = mem_r[a];
    npc = pc_r + 1'b1;
    dz  = 1'b0;
    case (c)
      CMD_NOP: ;
      CMD_AC_MQ: acc_r = mq_r;
      CMD_MQ_M: mq_r = m;
      CMD_M_AC: mem_r[a] = acc_r;
      CMD_AC_M: acc_r = m;
      CMD_NEG: acc_r = -m;
      CMD_ABS: acc_r = abs_word(m);
      CMD_NABS: acc_r = -abs_word(m);
      CMD_JUMP: npc = a;
      CMD_JUMPP: if (!acc_r[WORD_W-1]) npc = a;
      CMD_ADD: acc_r = acc_r + m;
      CMD_ADDA: acc_r = acc_r + abs_word(m);
      CMD_SUB: acc_r = acc_r - m;
      CMD_SUBA: acc_r = acc_r - abs_word(m);
      CMD_MUL: acc_r = mq_r * m;
      CMD_DIV: begin
        if (m == '0) begin
          dz = 1'b1;
        end else begin
          ma = abs_word(acc_r);
          mb = abs_word(m);
          q  = ma / mb;
          r  = ma % mb;
          if (acc_r[WORD_W-1] != m[WORD_W-1]) q = -q;
          if (acc_r[WORD_W-1]) r = -r;
          mq_r  = q;
          acc_r = r;
        end
      end
      CMD_PRELOAD: begin
        mem_r[a] = wd;
        npc = pc_r;
      end
      CMD_SETPC: npc = a;
      default: npc = pc_r;
    endcase
    pc_r = npc;
    expected_q.push_back('{acc: acc_r, mq: mq_r, pc: pc_r, dz: dz});
  endtask

  task automatic report(input string what, input logic [WORD_W-1:0] got,
                        input logic [WORD_W-1:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    pending = 0;
    acc_r = '0;
    mq_r = '0;
    pc_r = '0;
    foreach (mem_r[i]) mem_r[i] = '0;
  end

  always @(posedge clk) begin
    cpu_state_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("unexpected result at %0d", results_seen);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_acc_value != e.acc) report("acc", out_acc_value, e.acc);
          if (out_mq_value != e.mq) report("mq", out_mq_value, e.mq);
          if (out_pc_value != e.pc) report("pc", out_pc_value, e.pc);
          if (out_divide_by_zero != e.dz) report("dz", out_divide_by_zero, e.dz);
        end
      end
      if (in_valid && in_ready) execute(in_command, in_address, in_word_data);
      pending = expected_q.size();
    end
  end
endmodule

### sim/tb.sv
// Testbench top for accumulator_cpu_execute_unit: drives decoded requests in
// bursts, stalls the result side, gives the verdict. Depends on acpu_pkg, acpu_checker.
module tb;
  import acpu_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic [ADDR_W-1:0] in_address = '0;
  logic signed [WORD_W-1:0] in_word_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [WORD_W-1:0] out_acc_value, out_mq_value;
  logic [ADDR_W-1:0] out_pc_value;
  logic out_divide_by_zero;
  int fail_count, pending, results_seen;
  int idle_cycles = 0;
  int hold_off = 0;

  localparam int WATCHDOG = 20000;

  always #5 clk = ~clk;

  accumulator_cpu_execute_unit u_top (.*);

  acpu_checker u_chk (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog expired");
      $display("[accumulator_cpu_execute_unit] ERROR");
      $finish;
    end
  end

  // result side: random stall pattern plus occasional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (rst_n && $urandom_range(0, 299) == 0) begin
      hold_off <= $urandom_range(200, 400);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                      input logic [WORD_W-1:0] wd);
    in_valid <= 1'b1;
    in_command <= c;
    in_address <= a;
    in_word_data <= wd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [CMD_W-1:0] c;
    logic [ADDR_W-1:0] a;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every command, special cases
    send(CMD_PRELOAD, 10'd0, 32'h8000_0000);
    send(CMD_PRELOAD, 10'd1023, 32'hffff_ffff);
    send(CMD_PRELOAD, 10'd5, 32'h7fff_ffff);
    send(CMD_AC_M, 10'd0, '0);
    send(CMD_NEG, 10'd0, '0);
    send(CMD_ABS, 10'd0, '0);
    send(CMD_NABS, 10'd5, '0);
    send(CMD_MQ_M, 10'd1023, '0);
    send(CMD_AC_M, 10'd0, '0);
    send(CMD_DIV, 10'd1023, '0);
    send(CMD_DIV, 10'd7, '0);
    send(CMD_AC_MQ, 10'd0, '0);
    send(CMD_MUL, 10'd5, '0);
    send(CMD_ADD, 10'd5, '0);
    send(CMD_ADDA, 10'd0, '0);
    send(CMD_SUB, 10'd1023, '0);
    send(CMD_SUBA, 10'd0, '0);
    send(CMD_M_AC, 10'd9, '0);
    send(CMD_JUMPP, 10'd1023, '0);
    send(CMD_JUMP, 10'd1023, '0);
    send(CMD_NOP, 10'd0, '0);
    send(CMD_SETPC, 10'd512, '0);
    send(5'd18, 10'd3, 32'h1234_5678);
    send(5'd31, 10'd1023, 32'hffff_ffff);
    drain();
    // random: mostly valid commands on a small address window
    for (int i = 0; i < 1250; i++) begin
      c = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                       : 5'($urandom_range(0, 17));
      a = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
      send(c, a, rand_word());
      if (i == 600) drain();
      else gap();
    end
    drain();
    repeat (50) @(posedge clk);
    $display("ran %0d results over all 18 commands, undefined codes and wrap cases",
             results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[accumulator_cpu_execute_unit] OK");
    end else begin
      $display("[accumulator_cpu_execute_unit] ERROR");
    end
    $finish;
  end
endmodule
